// ===== hw/rtl/wws_pkg.sv =====
// wws_pkg: shared types, constants and the microcode rom of the worker wake selector
// no dependencies; used by wws_ram, wws_seq and worker_wake_selector
package wws_pkg;

   // defaults and fixed field widths
   localparam int SLOTS_DEF  = 16;
   localparam int IDX_W_DEF  = $clog2(SLOTS_DEF);
   localparam int MODE_W     = 3;
   localparam int SLOT_W     = 4;
   // wide enough to compare a slot index against any slot count
   localparam int SLOT_CMP_W = 8;

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_REGISTER      = 3'd0,
      MODE_UNREGISTER    = 3'd1,
      MODE_MARK_FULL     = 3'd2,
      MODE_MARK_NOT_FULL = 3'd3,
      MODE_RR_WAKE       = 3'd4,
      MODE_RECENT_WAKE   = 3'd5
   } mode_type;

   // microprogram addresses
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REG,
      ST_APPEND,
      ST_NF,
      ST_UNREG,
      ST_FULL,
      ST_RM_RD,
      ST_RM_STEP,
      ST_RM_END,
      ST_RR_INIT,
      ST_RR_STEP,
      ST_MR_RD,
      ST_MR_TAKE,
      ST_RESP
   } step_type;

   // jump conditions
   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_REG_SKIP,
      COND_NF_DO,
      COND_UNREG_SKIP,
      COND_FULL_DO,
      COND_RM_LAST,
      COND_EXT_ZERO,
      COND_SCAN_END,
      COND_LIST_EMPTY,
      COND_OUT_BUSY
   } cond_type;

   // datapath controls, one bit per micro-operation
   typedef struct packed {
      logic take;
      logic set_pres;
      logic clr_pres;
      logic grow;
      logic append;
      logic rm_rd;
      logic rm_step;
      logic rm_end;
      logic scan_init;
      logic scan_step;
      logic last_rd;
      logic last_take;
      logic resp;
   } ctl_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic no_req;
      logic reg_skip;
      logic nf_do;
      logic unreg_skip;
      logic full_do;
      logic rm_last;
      logic ext_zero;
      logic scan_end;
      logic list_empty;
      logic out_busy;
   } flags_type;

   // one control word of the microprogram
   typedef struct packed {
      ctl_type  ctl;
      cond_type cond;
      step_type tgt_t;
      step_type tgt_f;
      logic     dispatch;
   } uword_type;

   // microprogram rom
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w          = '0;
      w.cond     = COND_ALWAYS;
      w.tgt_t    = ST_RESP;
      w.tgt_f    = ST_RESP;
      w.dispatch = 1'b0;
      unique case (step)
         ST_IDLE: begin
            w.ctl.take = 1'b1;
            w.cond     = COND_NO_REQ;
            w.tgt_t    = ST_IDLE;
            w.dispatch = 1'b1;
         end
         ST_REG: begin
            w.ctl.set_pres = 1'b1;
            w.ctl.grow     = 1'b1;
            w.cond         = COND_REG_SKIP;
            w.tgt_f        = ST_APPEND;
         end
         ST_APPEND: begin
            w.ctl.append = 1'b1;
         end
         ST_NF: begin
            w.cond  = COND_NF_DO;
            w.tgt_t = ST_APPEND;
         end
         ST_UNREG: begin
            w.ctl.clr_pres = 1'b1;
            w.cond         = COND_UNREG_SKIP;
            w.tgt_f        = ST_RM_RD;
         end
         ST_FULL: begin
            w.cond  = COND_FULL_DO;
            w.tgt_t = ST_RM_RD;
         end
         ST_RM_RD: begin
            w.ctl.rm_rd = 1'b1;
            w.tgt_t     = ST_RM_STEP;
         end
         ST_RM_STEP: begin
            w.ctl.rm_step = 1'b1;
            w.cond        = COND_RM_LAST;
            w.tgt_t       = ST_RM_END;
            w.tgt_f       = ST_RM_STEP;
         end
         ST_RM_END: begin
            w.ctl.rm_end = 1'b1;
         end
         ST_RR_INIT: begin
            w.ctl.scan_init = 1'b1;
            w.cond          = COND_EXT_ZERO;
            w.tgt_f         = ST_RR_STEP;
         end
         ST_RR_STEP: begin
            w.ctl.scan_step = 1'b1;
            w.cond          = COND_SCAN_END;
            w.tgt_f         = ST_RR_STEP;
         end
         ST_MR_RD: begin
            w.ctl.last_rd = 1'b1;
            w.cond        = COND_LIST_EMPTY;
            w.tgt_f       = ST_MR_TAKE;
         end
         ST_MR_TAKE: begin
            w.ctl.last_take = 1'b1;
         end
         ST_RESP: begin
            w.ctl.resp = 1'b1;
            w.cond     = COND_OUT_BUSY;
            w.tgt_f    = ST_IDLE;
         end
         default: begin
            w.tgt_t = ST_IDLE;
            w.tgt_f = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   // first microprogram step of each mode
   function automatic step_type dispatch_entry(input logic [MODE_W-1:0] mode);
      step_type s;
      s = ST_RESP;
      unique case (mode)
         MODE_REGISTER:      s = ST_REG;
         MODE_UNREGISTER:    s = ST_UNREG;
         MODE_MARK_FULL:     s = ST_FULL;
         MODE_MARK_NOT_FULL: s = ST_NF;
         MODE_RR_WAKE:       s = ST_RR_INIT;
         MODE_RECENT_WAKE:   s = ST_MR_RD;
         default:            s = ST_RESP;
      endcase
      return s;
   endfunction

endpackage

// ===== hw/rtl/wws_ram.sv =====
// wws_ram: generic single-write, single-read ram with registered read data
// depends on wws_pkg for default sizes
module wws_ram #(
   parameter int WIDTH = wws_pkg::IDX_W_DEF,
   parameter int DEPTH = wws_pkg::SLOTS_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/wws_seq.sv =====
// wws_seq: microprogram sequencer, step counter with conditional jumps and mode dispatch
// depends on wws_pkg for the rom, control and status types
module wws_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [wws_pkg::MODE_W-1:0] req_mode,
   input  wws_pkg::flags_type         flags,
   output wws_pkg::ctl_type           ctl
);

   wws_pkg::step_type  upc_ff;
   wws_pkg::step_type  upc_in;
   wws_pkg::uword_type word;
   logic               cond_true;

   assign word = wws_pkg::ucode_rom(upc_ff);

   // jump condition select
   always_comb begin
      unique case (word.cond)
         wws_pkg::COND_ALWAYS:     cond_true = 1'b1;
         wws_pkg::COND_NO_REQ:     cond_true = flags.no_req;
         wws_pkg::COND_REG_SKIP:   cond_true = flags.reg_skip;
         wws_pkg::COND_NF_DO:      cond_true = flags.nf_do;
         wws_pkg::COND_UNREG_SKIP: cond_true = flags.unreg_skip;
         wws_pkg::COND_FULL_DO:    cond_true = flags.full_do;
         wws_pkg::COND_RM_LAST:    cond_true = flags.rm_last;
         wws_pkg::COND_EXT_ZERO:   cond_true = flags.ext_zero;
         wws_pkg::COND_SCAN_END:   cond_true = flags.scan_end;
         wws_pkg::COND_LIST_EMPTY: cond_true = flags.list_empty;
         wws_pkg::COND_OUT_BUSY:   cond_true = flags.out_busy;
         default:                  cond_true = 1'b1;
      endcase
   end

   // next step
   always_comb begin
      if (cond_true) begin
         upc_in = word.tgt_t;
      end else if (word.dispatch) begin
         upc_in = wws_pkg::dispatch_entry(req_mode);
      end else begin
         upc_in = word.tgt_f;
      end
   end

   // control outputs
   always_comb begin
      ctl = word.ctl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= wws_pkg::ST_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

`ifndef SYNTHESIS
   // a request is only taken from the idle step, which is then left
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl.take && !flags.no_req) |=> (upc_ff != wws_pkg::ST_IDLE))
      else $error("sequencer stayed idle after taking a request");
`endif

endmodule

// ===== hw/rtl/worker_wake_selector.sv =====
// Worker wake selector: a table of SLOTS worker slots with present marks and an
// ordered not-full list, driven by a small microprogram. One request word gives one
// response word. Register, and mark-not-full on a present slot, append the slot to
// the list when it is not yet listed; most-recent wake reads the last list entry
// unless the list is empty; the unused modes go straight to the response step.
// Unregister and mark-full walk the not-full list one entry a cycle through the
// single read port of the list memory when the slot is listed (and, for mark-full,
// present). Round-robin wake tests one slot a cycle from the rotate pointer, up to
// the table extent. The idle step that takes the next request follows the response
// load directly, even while that response is still stalled; a stalled response
// keeps the following one waiting in the response step. No clearing pass is needed
// after reset.
module worker_wake_selector #(
   parameter int SLOTS = wws_pkg::SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [wws_pkg::MODE_W-1:0] req_mode,
   input  logic [wws_pkg::SLOT_W-1:0] req_slot,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_woken,
   output logic [wws_pkg::SLOT_W-1:0] rsp_woken_slot
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int LEN_W = $clog2(SLOTS + 1);
   localparam int CMP_W = wws_pkg::SLOT_CMP_W;

   wws_pkg::ctl_type   ctl;
   wws_pkg::flags_type flags;

   // control state
   logic [SLOTS-1:0] present_ff, present_in;
   logic [SLOTS-1:0] listed_ff, listed_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] ext_ff, ext_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [wws_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]           i_ff, i_in;
   logic [LEN_W-1:0]           j_ff, j_in;
   logic [IDX_W-1:0]           p_ff, p_in;
   logic [LEN_W-1:0]           n_ff, n_in;
   logic                       woken_ff, woken_in;
   logic [IDX_W-1:0]           wslot_ff, wslot_in;
   logic                       rsp_woken_ff, rsp_woken_in;
   logic [wws_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // datapath helpers
   logic             slot_ok;
   logic [IDX_W-1:0] slot_idx;
   logic             pres_s;
   logic             listed_s;
   logic             can_append;
   logic             keep;
   logic             hit;
   logic [LEN_W-1:0] p_wide;
   logic [IDX_W-1:0] p_next;
   logic [LEN_W-1:0] n_inc;
   logic [LEN_W-1:0] len_dec;
   logic [LEN_W-1:0] slot_ext;
   logic             out_busy;

   // list memory
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [IDX_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [IDX_W-1:0] ram_rd_data;

   wws_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_mode (req_mode),
      .flags    (flags),
      .ctl      (ctl)
   );

   wws_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SLOTS)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // slot decode
   assign slot_ok    = CMP_W'(slot_ff) < CMP_W'(SLOTS);
   assign slot_idx   = IDX_W'(slot_ff);
   assign pres_s     = slot_ok & present_ff[slot_idx];
   assign listed_s   = slot_ok & listed_ff[slot_idx];
   assign can_append = slot_ok & (len_ff != LEN_W'(SLOTS));
   assign slot_ext   = LEN_W'(slot_idx) + LEN_W'(1);
   assign len_dec    = len_ff - LEN_W'(1);

   // list compaction and scan helpers
   assign keep   = ram_rd_data != slot_idx;
   assign hit    = present_ff[p_ff];
   assign p_wide = LEN_W'(p_ff) + LEN_W'(1);
   assign p_next = (p_wide == ext_ff) ? '0 : p_wide[IDX_W-1:0];
   assign n_inc  = n_ff + LEN_W'(1);

   assign out_busy = rsp_valid_ff & rsp_stall;

   // status for the sequencer
   always_comb begin
      flags.no_req     = !req_valid;
      flags.reg_skip   = !slot_ok | listed_s;
      flags.nf_do      = pres_s & !listed_s;
      flags.unreg_skip = !listed_s;
      flags.full_do    = pres_s & listed_s;
      flags.rm_last    = i_ff == len_ff;
      flags.ext_zero   = ext_ff == '0;
      flags.scan_end   = hit | (n_inc == ext_ff);
      flags.list_empty = len_ff == '0;
      flags.out_busy   = out_busy;
   end

   // list memory ports
   always_comb begin
      ram_wr_en   = (ctl.append & can_append) | (ctl.rm_step & keep);
      ram_wr_addr = ctl.rm_step ? j_ff[IDX_W-1:0] : len_ff[IDX_W-1:0];
      ram_wr_data = ctl.rm_step ? ram_rd_data : slot_idx;
      ram_rd_en   = ctl.rm_rd | (ctl.rm_step & (i_ff != len_ff)) | ctl.last_rd;
      if (ctl.rm_rd) begin
         ram_rd_addr = '0;
      end else if (ctl.last_rd) begin
         ram_rd_addr = len_dec[IDX_W-1:0];
      end else begin
         ram_rd_addr = i_ff[IDX_W-1:0];
      end
   end

   // datapath next values
   always_comb begin
      present_in   = present_ff;
      listed_in    = listed_ff;
      len_in       = len_ff;
      ext_in       = ext_ff;
      ptr_in       = ptr_ff;
      slot_in      = slot_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      woken_in     = woken_ff;
      wslot_in     = wslot_ff;
      rsp_woken_in = rsp_woken_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_valid_in = out_busy;

      // request word capture
      if (ctl.take && req_valid) begin
         slot_in  = req_slot;
         woken_in = 1'b0;
         wslot_in = '0;
      end
      // registration and table extent
      if (ctl.set_pres && slot_ok) begin
         present_in[slot_idx] = 1'b1;
      end
      if (ctl.grow && slot_ok && (ext_ff < slot_ext)) begin
         ext_in = slot_ext;
      end
      if (ctl.clr_pres && slot_ok) begin
         present_in[slot_idx] = 1'b0;
      end
      // append to the not-full list
      if (ctl.append && can_append) begin
         len_in              = len_ff + LEN_W'(1);
         listed_in[slot_idx] = 1'b1;
      end
      // removal walk: read at i, write kept entries at j
      if (ctl.rm_rd) begin
         i_in = LEN_W'(1);
         j_in = '0;
      end
      if (ctl.rm_step) begin
         if (i_ff != len_ff) begin
            i_in = i_ff + LEN_W'(1);
         end
         if (keep) begin
            j_in = j_ff + LEN_W'(1);
         end
      end
      if (ctl.rm_end) begin
         len_in              = j_ff;
         listed_in[slot_idx] = 1'b0;
      end
      // round-robin scan
      if (ctl.scan_init) begin
         p_in = ptr_ff;
         n_in = '0;
      end
      if (ctl.scan_step) begin
         if (hit) begin
            woken_in = 1'b1;
            wslot_in = p_ff;
            ptr_in   = p_next;
         end else begin
            p_in = p_next;
            n_in = n_inc;
         end
      end
      // most-recent wake
      if (ctl.last_take) begin
         woken_in = 1'b1;
         wslot_in = ram_rd_data;
      end
      // response register load
      if (ctl.resp && !out_busy) begin
         rsp_valid_in = 1'b1;
         rsp_woken_in = woken_ff;
         rsp_slot_in  = wws_pkg::SLOT_W'(wslot_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         listed_ff    <= '0;
         len_ff       <= '0;
         ext_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff   <= present_in;
         listed_ff    <= listed_in;
         len_ff       <= len_in;
         ext_ff       <= ext_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      p_ff         <= p_in;
      n_ff         <= n_in;
      woken_ff     <= woken_in;
      wslot_ff     <= wslot_in;
      rsp_woken_ff <= rsp_woken_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign req_stall      = !ctl.take;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_woken      = rsp_woken_ff;
   assign rsp_woken_slot = rsp_slot_ff;

`ifndef SYNTHESIS
   // every listed slot holds exactly one list entry
   a_listed_count: assert property (@(posedge clock) disable iff (reset)
      $countones(listed_ff) == int'(len_ff))
      else $error("listed marks disagree with list length");

   // list never grows past the table
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(SLOTS))
      else $error("list length beyond slot count");

   // rotate pointer stays inside the table extent
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (ext_ff != '0) |-> (LEN_W'(ptr_ff) < ext_ff))
      else $error("rotate pointer outside table extent");

   // a response with no wake reports slot zero
   a_no_wake_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_woken) |-> (rsp_woken_slot == '0))
      else $error("nonzero slot on a response without wake");
`endif

endmodule
